FILE: design/tars_pkg.sv
`timescale 1ns / 1ps
package tars_pkg;

   localparam int PIX_W     = 16;
   localparam int MARGIN_W  = 12;
   localparam int BOUND_W   = 18;
   localparam int DIFF_W    = 17;
   localparam int PROD_W    = DIFF_W + PIX_W;
   localparam int DIV_STEPS = PIX_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic signed [BOUND_W-1:0] BOUND_LOW_RESET  = 18'sh07E00;
   localparam logic signed [BOUND_W-1:0] BOUND_HIGH_RESET = 18'sh08200;
   localparam logic [PIX_W-1:0]          FULL_SCALE       = 16'hFFFF;
   localparam logic [PIX_W-1:0]          RUN_MIN_RESET    = 16'hFFFF;
   localparam logic [PIX_W-1:0]          RUN_MAX_RESET    = 16'h0000;

   localparam logic REG_MARGIN_LOW  = 1'b0;
   localparam logic REG_MARGIN_HIGH = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] scaled_pixel;
      logic             last_pixel;
      logic [PIX_W-1:0] found_min;
      logic [PIX_W-1:0] found_max;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clamp;
      logic out_free;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

FILE: design/thermal_auto_range_stretch_unit.sv
`timescale 1ns / 1ps
// A pixel inside the bounds passes through a multiply and then the 16-step
// restoring divider that forms each quotient bit in turn; a pixel clamped to 0
// or full scale skips the divider. A new word is taken only once the last result
// has moved into the result register, which waits while rsp is stalled.
// Reset (synchronous, active high): bounds 0x7E00 / 0x8200, min/max trackers
// set to 0xFFFF / 0x0000, margins 0, result register empty.
module thermal_auto_range_stretch_unit import tars_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [MARGIN_W-1:0] margin_low_ff, margin_high_ff;
   logic                wr_en;
   cmd_type             cmd;
   status_type          status;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_low_ff  <= '0;
         margin_high_ff <= '0;
      end else if (wr_en) begin
         if (paddr[2] == REG_MARGIN_LOW) begin
            margin_low_ff <= pwdata[MARGIN_W-1:0];
         end else begin
            margin_high_ff <= pwdata[MARGIN_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_MARGIN_HIGH) begin
         prdata = DATA_W'(margin_high_ff);
      end else begin
         prdata = DATA_W'(margin_low_ff);
      end
   end

   tars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tars_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_word    (req_word),
      .margin_low  (margin_low_ff),
      .margin_high (margin_high_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

FILE: design/tars_ctrl.sv
`timescale 1ns / 1ps
module tars_ctrl import tars_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = '0;
            // skip the divide for clamped pixels
            state_in = status.clamp ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: design/tars_dpath.sv
`timescale 1ns / 1ps
module tars_dpath import tars_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  req_word_type        req_word,
   input  logic [MARGIN_W-1:0] margin_low,
   input  logic [MARGIN_W-1:0] margin_high,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_word_type        rsp_word
);

   logic signed [BOUND_W-1:0] bound_low_ff, bound_low_in;
   logic signed [BOUND_W-1:0] bound_high_ff, bound_high_in;
   logic [PIX_W-1:0]          run_min_ff, run_min_in;
   logic [PIX_W-1:0]          run_max_ff, run_max_in;
   logic                      below_ff, above_ff, last_ff;
   logic [PIX_W-1:0]          found_min_ff, found_max_ff;
   logic [DIFF_W-1:0]         num_ff, den_ff;
   logic [DIFF_W-1:0]         rem_ff, rem_in;
   logic [PIX_W-1:0]          quo_ff, quo_in;
   logic                      rsp_valid_ff;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   logic signed [BOUND_W-1:0] pix_s, num_s, den_s;
   logic                      below, above;
   logic [PIX_W-1:0]          new_min, new_max;
   logic [PROD_W-1:0]         prod;
   logic [DIFF_W:0]           shifted;
   logic [DIFF_W+1:0]         trial;

   always_comb begin
      pix_s   = BOUND_W'($signed({2'b00, req_word.pixel}));
      below   = pix_s <= bound_low_ff;
      above   = (bound_high_ff <= bound_low_ff) || (pix_s >= bound_high_ff);
      num_s   = pix_s - bound_low_ff;
      den_s   = bound_high_ff - bound_low_ff;
      new_min = (req_word.pixel < run_min_ff) ? req_word.pixel : run_min_ff;
      new_max = (req_word.pixel > run_max_ff) ? req_word.pixel : run_max_ff;

      bound_low_in  = bound_low_ff;
      bound_high_in = bound_high_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      if (cmd.load) begin
         run_min_in = new_min;
         run_max_in = new_max;
         if (req_word.frame_end) begin
            bound_low_in  = $signed({2'b00, new_min}) - $signed({6'b0, margin_low});
            bound_high_in = $signed({2'b00, new_max}) + $signed({6'b0, margin_high});
            run_min_in    = RUN_MIN_RESET;
            run_max_in    = RUN_MAX_RESET;
         end
      end
   end

   always_comb begin
      prod    = PROD_W'(num_ff) * PROD_W'(FULL_SCALE);
      shifted = {rem_ff, quo_ff[PIX_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.mul) begin
         rem_in = prod[PROD_W-1:PIX_W];
         quo_in = prod[PIX_W-1:0];
      end else if (cmd.div_step) begin
         rem_in = trial[DIFF_W+1] ? shifted[DIFF_W-1:0] : trial[DIFF_W-1:0];
         quo_in = {quo_ff[PIX_W-2:0], ~trial[DIFF_W+1]};
      end
   end

   always_comb begin
      rsp_word_in.last_pixel = last_ff;
      rsp_word_in.found_min  = found_min_ff;
      rsp_word_in.found_max  = found_max_ff;
      if (below_ff) begin
         rsp_word_in.scaled_pixel = '0;
      end else if (above_ff) begin
         rsp_word_in.scaled_pixel = FULL_SCALE;
      end else begin
         rsp_word_in.scaled_pixel = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_low_ff  <= BOUND_LOW_RESET;
         bound_high_ff <= BOUND_HIGH_RESET;
         run_min_ff    <= RUN_MIN_RESET;
         run_max_ff    <= RUN_MAX_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bound_low_ff  <= bound_low_in;
         bound_high_ff <= bound_high_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         below_ff     <= below;
         above_ff     <= above;
         last_ff      <= req_word.frame_end;
         found_min_ff <= req_word.frame_end ? new_min : '0;
         found_max_ff <= req_word.frame_end ? new_max : '0;
         num_ff       <= num_s[DIFF_W-1:0];
         den_ff       <= den_s[DIFF_W-1:0];
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.out_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign status.clamp    = below_ff | above_ff;
   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

endmodule
